// ===== rtl/core/owlpe_pkg.sv =====
// Package for the one-wire LED pixel encoder: item types, config register
// map, reset values and small helpers. No dependencies.

package owlpe_pkg;

  // Color word length shifted onto the line
  localparam int COLOR_BITS = 24;
  localparam int BITS_W     = $clog2(COLOR_BITS + 1);

  // Tick queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Config port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICKS_W    = 16;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

  // Reset values of the config registers
  localparam logic [7:0]         RST_ZERO_HIGH = 8'd6;
  localparam logic [7:0]         RST_ONE_HIGH  = 8'd12;
  localparam logic [7:0]         RST_ZERO_LOW  = 8'd12;
  localparam logic [7:0]         RST_ONE_LOW   = 8'd6;
  localparam logic [TICKS_W-1:0] RST_LATCH     = 16'd36000;

  // Input item: one tick, possibly offering a pixel
  typedef struct packed {
    logic        pixel_valid;
    logic [23:0] pixel_color;
    logic        pixel_last;
  } in_item_t;

  // Result item: line state for one tick
  typedef struct packed {
    logic line_level;
    logic pixel_taken;
    logic frame_done;
  } out_item_t;

  // Classified tick as held in the queue
  typedef struct packed {
    logic                  offer;
    logic                  last;
    logic [COLOR_BITS-1:0] color;
  } tick_t;

  // Config register file contents
  typedef struct packed {
    logic [7:0]         zero_high;
    logic [7:0]         one_high;
    logic [7:0]         zero_low;
    logic [7:0]         one_low;
    logic [TICKS_W-1:0] latch;
  } cfg_t;

  // Waveform phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_e;

  // A duration of zero counts as one tick
  function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
    at_least_one = (v == '0) ? TICKS_W'(1) : v;
  endfunction

endpackage

// ===== rtl/core/owlpe_cfg.sv =====
// Config register file of the one-wire LED pixel encoder.
// Depends on owlpe_pkg.

module owlpe_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [owlpe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [owlpe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output owlpe_pkg::cfg_t                   cfg_o
);
  import owlpe_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        CFG_ZERO_HIGH: cfg_d.zero_high = cfg_data_i[7:0];
        CFG_ONE_HIGH:  cfg_d.one_high  = cfg_data_i[7:0];
        CFG_ZERO_LOW:  cfg_d.zero_low  = cfg_data_i[7:0];
        CFG_ONE_LOW:   cfg_d.one_low   = cfg_data_i[7:0];
        CFG_LATCH:     cfg_d.latch     = cfg_data_i[TICKS_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_high <= RST_ZERO_HIGH;
      cfg_q.one_high  <= RST_ONE_HIGH;
      cfg_q.zero_low  <= RST_ZERO_LOW;
      cfg_q.one_low   <= RST_ONE_LOW;
      cfg_q.latch     <= RST_LATCH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/owlpe_front.sv =====
// Front end of the one-wire LED pixel encoder: takes tick items, classifies
// them and holds them in a short queue for the back end. Depends on owlpe_pkg.

module owlpe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  owlpe_pkg::in_item_t   in_data_i,
  output logic                  q_valid_o,
  output owlpe_pkg::tick_t      q_item_o,
  input  logic                  q_pop_i
);
  import owlpe_pkg::*;

  tick_t             entry_q [QUEUE_DEPTH];
  tick_t             cls;
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;

  // Classify: last only counts with an offer, color trimmed to COLOR_BITS
  always_comb begin
    cls.offer = in_data_i.pixel_valid;
    cls.last  = in_data_i.pixel_valid & in_data_i.pixel_last;
    cls.color = COLOR_BITS'(in_data_i.pixel_color);
  end

  assign in_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i & in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, q_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/core/owlpe_back.sv =====
// Back end of the one-wire LED pixel encoder: runs the bit waveform state
// machine one queued tick per cycle into an output register, as long as
// that register is free or draining. Depends on owlpe_pkg.

module owlpe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  owlpe_pkg::tick_t     q_item_i,
  output logic                 q_pop_o,
  input  owlpe_pkg::cfg_t      cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output owlpe_pkg::out_item_t out_data_o
);
  import owlpe_pkg::*;

  phase_e                phase_q, phase_d, cur_phase;
  logic [TICKS_W-1:0]    ticks_q, ticks_d, cur_ticks, dec_ticks, ld_ticks;
  logic [COLOR_BITS-1:0] shift_q, shift_d, cur_shift, shifted;
  logic [BITS_W-1:0]     bits_q, bits_d, cur_bits, bits_dec;
  logic                  ending_q, ending_d, cur_ending;
  logic                  idle_load, level, taken, done;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  // Take a tick when the output register is free or draining
  assign q_pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  // Duration of the first high phase of an offered pixel
  assign ld_ticks = at_least_one(TICKS_W'(q_item_i.color[COLOR_BITS-1] ?
                                          cfg_i.one_high : cfg_i.zero_high));

  // Pixel load from idle happens before the phase is processed
  assign idle_load = (phase_q == PH_IDLE) & q_item_i.offer;

  always_comb begin
    if (idle_load) begin
      cur_phase  = PH_HIGH;
      cur_ticks  = ld_ticks;
      cur_shift  = q_item_i.color;
      cur_bits   = BITS_W'(COLOR_BITS);
      cur_ending = q_item_i.last;
    end else begin
      cur_phase  = phase_q;
      cur_ticks  = ticks_q;
      cur_shift  = shift_q;
      cur_bits   = bits_q;
      cur_ending = ending_q;
    end
  end

  assign dec_ticks = cur_ticks - 1'b1;
  assign shifted   = cur_shift << 1;
  assign bits_dec  = (cur_bits != '0) ? cur_bits - 1'b1 : '0;

  // Next state
  always_comb begin
    phase_d  = cur_phase;
    ticks_d  = cur_ticks;
    shift_d  = cur_shift;
    bits_d   = cur_bits;
    ending_d = cur_ending;
    level    = 1'b0;
    taken    = idle_load;
    done     = 1'b0;
    case (cur_phase)
      PH_HIGH: begin
        level   = 1'b1;
        ticks_d = dec_ticks;
        if (dec_ticks == '0) begin
          phase_d = PH_LOW;
          ticks_d = at_least_one(TICKS_W'(cur_shift[COLOR_BITS-1] ?
                                          cfg_i.one_low : cfg_i.zero_low));
        end
      end
      PH_LOW: begin
        ticks_d = dec_ticks;
        if (dec_ticks == '0) begin
          shift_d = shifted;
          bits_d  = bits_dec;
          if (bits_dec != '0) begin
            phase_d = PH_HIGH;
            ticks_d = at_least_one(TICKS_W'(shifted[COLOR_BITS-1] ?
                                            cfg_i.one_high : cfg_i.zero_high));
          end else if (cur_ending) begin
            phase_d = PH_LATCH;
            ticks_d = at_least_one(cfg_i.latch);
          end else if (q_item_i.offer) begin
            // back to back pixel
            phase_d  = PH_HIGH;
            ticks_d  = ld_ticks;
            shift_d  = q_item_i.color;
            bits_d   = BITS_W'(COLOR_BITS);
            ending_d = q_item_i.last;
            taken    = 1'b1;
          end else begin
            phase_d = PH_IDLE;
            ticks_d = '0;
          end
        end
      end
      PH_LATCH: begin
        ticks_d = dec_ticks;
        if (dec_ticks == '0) begin
          done     = 1'b1;
          phase_d  = PH_IDLE;
          ending_d = 1'b0;
        end
      end
      default: begin
        level = 1'b0;
      end
    endcase
  end

  // Result item
  always_comb begin
    out_d.line_level  = level;
    out_d.pixel_taken = taken;
    out_d.frame_done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      shift_q     <= '0;
      bits_q      <= '0;
      ending_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q  <= phase_d;
        ticks_q  <= ticks_d;
        shift_q  <= shift_d;
        bits_q   <= bits_d;
        ending_q <= ending_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/one_wire_led_pixel_encoder.sv =====
// Channel  | Signals                               | Item
// ---------+---------------------------------------+---------------------------
// in       | in_valid_i, in_ready_o, in_data_i     | one tick, optional pixel
// out      | out_valid_o, out_ready_i, out_data_o  | line level, taken, done
// cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | reg write
//
// One tick item is taken per cycle when the output side keeps up; its result
// item passes through the tick queue, then the waveform step into the output
// register.
// The single waveform step per cycle in the back end sets the rate.
// Reset: timing registers take their defaults, phase idle, queue empty.
// Output stalls fill the two-entry tick queue before in_ready_o drops.
// Top level of the one-wire LED pixel encoder; uses owlpe_pkg, owlpe_cfg,
// owlpe_front and owlpe_back.

module one_wire_led_pixel_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  owlpe_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output owlpe_pkg::out_item_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [owlpe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [owlpe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import owlpe_pkg::*;

  cfg_t  cfg;
  tick_t q_item;
  logic  q_valid, q_pop;

  owlpe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  owlpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  owlpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Back end never pops an empty queue
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("tick popped from empty queue");

  // Input side only blocks when the queue holds items
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("input stalled with empty queue");

  // A pixel is never taken on the tick that ends the latch period
  a_done_not_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.frame_done && out_data_o.pixel_taken))
    else $error("frame_done and pixel_taken on the same tick");

  // A free output register accepts a queued tick in the same cycle
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !out_valid_o) |=> out_valid_o)
    else $error("queued tick not moved to free output register");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for one_wire_led_pixel_encoder: tick items with pixel offers in,
// one line sample per tick out, checked against a tick-accurate line predictor.
// Depends on owlpe_pkg and the encoder RTL only.

module tb;
  import owlpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50_000;
  localparam int unsigned HOLD_CYCLES = 400;
  // index that maps to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  // predictor state of the serial line
  typedef struct packed {
    logic [COLOR_BITS-1:0] shift;
    logic [5:0]            bits_left;
    logic [15:0]           ticks;
    phase_e                phase;
    logic                  ending;
  } line_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t        timing;
  line_state_t plan_state;   // advanced while items are generated
  line_state_t line_state;   // advanced as items are accepted
  in_item_t    tick_q[$];
  out_item_t   line_q[$];
  int unsigned queued_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;

  one_wire_led_pixel_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock and one reset pulse
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor

  // a programmed duration of zero still lasts one tick
  function automatic logic [15:0] min_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic line_state_t begin_bit(input line_state_t s);
    line_state_t n;
    n = s;
    n.phase = PH_HIGH;
    n.ticks = min_one(n.shift[COLOR_BITS-1] ? 16'(timing.one_high) : 16'(timing.zero_high));
    return n;
  endfunction

  function automatic line_state_t load_color(input line_state_t s, input in_item_t it);
    line_state_t n;
    n = s;
    n.shift     = it.pixel_color[COLOR_BITS-1:0];
    n.bits_left = 6'(COLOR_BITS);
    n.ending    = it.pixel_last;
    return begin_bit(n);
  endfunction

  // one tick of the waveform: returns the line sample, updates the state
  function automatic out_item_t encode_tick(inout line_state_t s, input in_item_t it);
    out_item_t r;
    r = '0;
    if (s.phase == PH_IDLE && it.pixel_valid) begin
      s = load_color(s, it);
      r.pixel_taken = 1'b1;
    end
    case (s.phase)
      PH_HIGH: begin
        r.line_level = 1'b1;
        s.ticks = s.ticks - 16'd1;
        if (s.ticks == 16'd0) begin
          s.phase = PH_LOW;
          s.ticks = min_one(s.shift[COLOR_BITS-1] ? 16'(timing.one_low) : 16'(timing.zero_low));
        end
      end
      PH_LOW: begin
        s.ticks = s.ticks - 16'd1;
        if (s.ticks == 16'd0) begin
          s.shift = s.shift << 1;
          if (s.bits_left != 0) s.bits_left = s.bits_left - 6'd1;
          if (s.bits_left != 0) begin
            s = begin_bit(s);
          end else if (s.ending) begin
            s.phase = PH_LATCH;
            s.ticks = min_one(timing.latch);
          end else if (it.pixel_valid) begin
            // next pixel joins without a gap
            s = load_color(s, it);
            r.pixel_taken = 1'b1;
          end else begin
            s.phase = PH_IDLE;
            s.ticks = 16'd0;
          end
        end
      end
      PH_LATCH: begin
        s.ticks = s.ticks - 16'd1;
        if (s.ticks == 16'd0) begin
          r.frame_done = 1'b1;
          s.phase = PH_IDLE;
          s.ending = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- item generation

  function automatic bit push_tick(input in_item_t it);
    out_item_t r;
    r = encode_tick(plan_state, it);
    tick_q.push_back(it);
    queued_cnt++;
    return r.pixel_taken;
  endfunction

  // no pixel offered; color and last are noise
  function automatic in_item_t quiet_tick();
    in_item_t t;
    t.pixel_valid = 1'b0;
    t.pixel_color = 24'($urandom);
    t.pixel_last  = 1'($urandom_range(1));
    return t;
  endfunction

  function automatic void idle_ticks(input int unsigned n);
    repeat (n) void'(push_tick(quiet_tick()));
  endfunction

  // offer one pixel, held until the encoder takes it
  function automatic void send_pixel(input logic [23:0] color, input logic is_last);
    in_item_t t;
    t.pixel_valid = 1'b1;
    t.pixel_color = color;
    t.pixel_last  = is_last;
    while (push_tick(t) == 1'b0) begin
    end
  endfunction

  function automatic void drain_plan();
    while (plan_state.phase != PH_IDLE) void'(push_tick(quiet_tick()));
  endfunction

  // frames of 1..5 pixels: mostly back to back, some gaps, some stalls to idle,
  // and now and then a frame that never gets its last mark; stops once about
  // the given number of ticks is queued
  function automatic void random_frames(input int unsigned tick_budget);
    int unsigned first_cnt;
    int unsigned len;
    int unsigned pick;
    first_cnt = queued_cnt;
    while (queued_cnt - first_cnt < tick_budget) begin
      len = $urandom_range(1, 5);
      for (int unsigned k = 0; k < len && queued_cnt - first_cnt < tick_budget; k++) begin
        pick = $urandom_range(9);
        if (pick >= 8) begin
          drain_plan();
          idle_ticks($urandom_range(0, 3));
        end else if (pick >= 6) begin
          idle_ticks($urandom_range(1, 10));
        end
        send_pixel(24'($urandom), (k == len - 1) && ($urandom_range(9) != 0));
      end
    end
  endfunction

  // ---------------------------------------------------------------- sequencing

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ZERO_HIGH: timing.zero_high = val[7:0];
      CFG_ONE_HIGH:  timing.one_high  = val[7:0];
      CFG_ZERO_LOW:  timing.zero_low  = val[7:0];
      CFG_ONE_LOW:   timing.one_low   = val[7:0];
      CFG_LATCH:     timing.latch     = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [15:0] zh, input logic [15:0] oh,
                            input logic [15:0] zl, input logic [15:0] ol,
                            input logic [15:0] lt);
    write_reg(CFG_ZERO_HIGH, zh);
    write_reg(CFG_ONE_HIGH, oh);
    write_reg(CFG_ZERO_LOW, zl);
    write_reg(CFG_ONE_LOW, ol);
    write_reg(CFG_LATCH, lt);
  endtask

  task automatic set_pace(input int unsigned gap, input int unsigned stall);
    @(posedge clk_i);
    gap_pct   <= gap;
    stall_pct <= stall;
  endtask

  // bring the plan back to idle, then wait until every line sample is checked
  task automatic finish_phase();
    drain_plan();
    idle_ticks(2);
    while (checked_cnt != queued_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random 8 bit duration of 0 to hi, with noise in the unused upper byte
  function automatic logic [15:0] rand_dur(input int unsigned hi);
    return {8'($urandom), 8'($urandom_range(0, hi))};
  endfunction

  initial begin
    timing     = {RST_ZERO_HIGH, RST_ONE_HIGH, RST_ZERO_LOW, RST_ONE_LOW, RST_LATCH};
    plan_state = '0;
    line_state = '0;
    wait (rst_ni);
    @(posedge clk_i);

    // shortest timings: alternating and mixed bits back to back, then a stall
    // inside the frame lets the line go idle before the last pixel
    set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    set_pace(19, 19);
    send_pixel(24'hAAAAAA, 1'b0);
    send_pixel(24'h55FF00, 1'b0);
    drain_plan();
    idle_ticks(3);
    send_pixel(24'h7FFFFE, 1'b1);
    finish_phase();

    // zero in a duration register counts as one tick; dead index ignored
    set_timing(16'd0, 16'd2, 16'd0, 16'd0, 16'd0);
    write_reg(CFG_NO_REG, 16'hFFFF);
    set_pace(0, 0);
    send_pixel(24'h123456, 1'b1);
    finish_phase();

    // random frames under each pacing mode
    for (int unsigned p = 0; p < 4; p++) begin
      case (p)
        0: set_pace(0, 0);
        1: set_pace(77, 0);
        2: set_pace(0, 77);
        default: set_pace(19, 19);
      endcase
      set_timing(rand_dur(p == 3 ? 2 : 1), rand_dur(p == 3 ? 2 : 1),
                 rand_dur(p == 3 ? 2 : 1), rand_dur(p == 3 ? 2 : 1),
                 16'($urandom_range(0, 3)));
      random_frames(40);
      // long output stall while the sender keeps offering
      if (p == 0) hold_asks <= hold_asks + 1;
      finish_phase();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      // item taken at this edge: predict its line sample
      if (in_valid && in_ready_o) begin
        line_q.push_back(encode_tick(line_state, in_data));
      end
      if (!in_valid || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (line_q.size() == 0) begin
          $display("%0t: unexpected item %b", $time, out_data_o);
          errors++;
        end else begin
          out_item_t want;
          want = line_q.pop_front();
          if (want.line_level !== out_data_o.line_level) begin
            $display("%0t: line_level expected %b got %b", $time,
                     want.line_level, out_data_o.line_level);
            errors++;
          end
          if (want.pixel_taken !== out_data_o.pixel_taken) begin
            $display("%0t: pixel_taken expected %b got %b", $time,
                     want.pixel_taken, out_data_o.pixel_taken);
            errors++;
          end
          if (want.frame_done !== out_data_o.frame_done) begin
            $display("%0t: frame_done expected %b got %b", $time,
                     want.frame_done, out_data_o.frame_done);
            errors++;
          end
          checked_cnt++;
        end
      end
      // receiver pacing, with the occasional long hold-off
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_done != hold_asks) begin
        hold_done <= hold_asks;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/owlpe_pkg.sv
rtl/core/owlpe_cfg.sv
rtl/core/owlpe_front.sv
rtl/core/owlpe_back.sv
rtl/core/one_wire_led_pixel_encoder.sv
sim/tb.sv
